// ----- sv/socks_handshake_parser_assert.svh -----
// Assertion macros used by the checker file of the handshake parser.
// Depends on nothing; included by bare file name.
`ifndef SOCKS_HANDSHAKE_PARSER_ASSERT_SVH
`define SOCKS_HANDSHAKE_PARSER_ASSERT_SVH

// Assert an implication that must hold at every clock edge outside reset.
`define SHP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that a consequent holds in the next cycle after a condition.
`define SHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/shp_pkg.sv -----
// Types and constants of the SOCKS handshake parser.
// Used by the top level and the checker.
package shp_pkg;

  typedef enum logic [3:0] {
    PH_FREE       = 4'd0,
    PH_VERSION    = 4'd1,
    PH_V4_CMD     = 4'd2,
    PH_V5_NMETH   = 4'd3,
    PH_V5_METHODS = 4'd4,
    PH_V4_DEST    = 4'd5,
    PH_V4_USER    = 4'd6,
    PH_V5_HDR     = 4'd7,
    PH_V5_IPV4    = 4'd8,
    PH_V5_DOMLEN  = 4'd9,
    PH_V5_DOMAIN  = 4'd10,
    PH_V5_PORT    = 4'd11,
    PH_WAIT_V4    = 4'd12,
    PH_WAIT_V5    = 4'd13,
    PH_RELAY      = 4'd14
  } phase_t;

  typedef enum logic [2:0] {
    OK_REPLY    = 3'd0,
    OK_DEST     = 3'd1,
    OK_CONNECT  = 3'd2,
    OK_CLOSE    = 3'd3,
    OK_RELAY    = 3'd4,
    OK_NOWRELAY = 3'd5
  } out_kind_t;

  localparam logic [1:0] IK_BYTE     = 2'd0;
  localparam logic [1:0] IK_OUTCOME  = 2'd1;
  localparam logic [1:0] IK_OPEN     = 2'd2;
  localparam logic [1:0] IK_RESERVED = 2'd3;

  localparam logic [1:0] AT_IPV4   = 2'd0;
  localparam logic [1:0] AT_DOMAIN = 2'd1;
  localparam logic [1:0] AT_OTHER  = 2'd2;

  // Reply sequences that the emitter plays out.
  typedef enum logic [3:0] {
    RS_NONE,
    RS_GENERAL,     // 05 01 00 00, close
    RS_V4_REJECT,   // 00 5B + six zeros, close
    RS_V4_GRANT,    // 00 5A + six zeros, now relaying
    RS_V5_BADCMD,   // 05 07 00 01, bound, close
    RS_V5_UNREACH,  // 05 04 00 01, close
    RS_V5_OK,       // 05 00 00 01, bound, now relaying
    RS_V5_NOMETHOD, // 05 FF, close
    RS_V5_NOAUTH,   // 05 00
    RS_SINGLE       // one result carried in the job
  } seq_t;

  localparam int CFG_SERVER_PORT = 0;
  localparam int CFG_SERVER_ADDR = 1;

  // Per-slot state word kept in the memory.
  typedef struct packed {
    phase_t     phase;
    logic [7:0] byte_count;
    logic       noauth_seen;
    logic [7:0] port_high;
    logic [7:0] port_low;
    logic [1:0] dest_type;
  } slot_t;

  // Work handed from the parser to the result emitter.
  typedef struct packed {
    seq_t       seq;
    logic [3:0] conn;
    out_kind_t  kind;
    logic [7:0] data;
    logic [15:0] port;
    logic [1:0] atype;
  } job_t;

  // Length of a reply sequence in results.
  function automatic logic [3:0] seq_len(seq_t s);
    logic [3:0] n;
    n = 4'd0;
    unique case (s)
      RS_GENERAL:     n = 4'd5;
      RS_V4_REJECT:   n = 4'd9;
      RS_V4_GRANT:    n = 4'd9;
      RS_V5_BADCMD:   n = 4'd11;
      RS_V5_UNREACH:  n = 4'd5;
      RS_V5_OK:       n = 4'd11;
      RS_V5_NOMETHOD: n = 4'd3;
      RS_V5_NOAUTH:   n = 4'd2;
      RS_SINGLE:      n = 4'd1;
      default:        n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- sv/shp_in_if.sv -----
// Input channel interface of the SOCKS handshake parser.
// Depends on nothing but the language.
interface shp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] conn;
  logic [7:0] data_byte;
  logic       connect_ok;
  modport source (output valid, kind, conn, data_byte, connect_ok, input ready);
  modport sink (input valid, kind, conn, data_byte, connect_ok, output ready);
endinterface

// ----- sv/shp_out_if.sv -----
// Result channel interface of the SOCKS handshake parser.
// Depends on nothing but the language.
interface shp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_conn;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte;
  logic [15:0] dest_port;
  logic [1:0]  addr_type;
  logic        last;
  modport source (output valid, out_conn, out_kind, out_byte, dest_port, addr_type, last,
                  input ready);
  modport sink (input valid, out_conn, out_kind, out_byte, dest_port, addr_type, last,
                output ready);
endinterface

// ----- sv/socks_handshake_parser.sv -----
// SOCKS4/5 handshake parser: an accepted beat passes stage 1 and the job register before
// its first result. Throughput one input beat per cycle when it causes at most one result
// and the output is not stalled; a beat that causes a reply of n results holds the input
// until the result emitter has sent them. Per-slot state lives in one memory with a
// registered read, forwarded on back-to-back hits. Reset (rst_n low, synchronous) clears
// the control registers and a clearing pass frees every slot while no input beat is taken.
module socks_handshake_parser #(
  parameter int CONNECTIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  shp_in_if.sink      in_ch,
  shp_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

  // Configuration registers.
  logic [15:0] server_port_r;
  logic [31:0] server_addr_r;
  logic        cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_port_r <= '0;
      server_addr_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr == 3'(shp_pkg::CFG_SERVER_PORT * 4)) server_port_r <= cfg_pwdata[15:0];
      if (cfg_paddr == 3'(shp_pkg::CFG_SERVER_ADDR * 4)) server_addr_r <= cfg_pwdata;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == 3'(shp_pkg::CFG_SERVER_PORT * 4)) cfg_prdata = {16'd0, server_port_r};
    else if (cfg_paddr == 3'(shp_pkg::CFG_SERVER_ADDR * 4)) cfg_prdata = server_addr_r;
  end

  // Clearing pass over the slot memory after reset.
  logic          clr_busy_r;
  logic [AW-1:0] clr_idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (32'(clr_idx_r) == CONNECTIONS - 1) clr_busy_r <= 1'b0;
      clr_idx_r <= clr_idx_r + AW'(1);
    end
  end

  // Emitter side: job register, index of its current result.
  shp_pkg::job_t job_r;
  logic          job_v_r;
  logic [3:0]    job_idx_r;
  logic          job_done;
  logic          job_free;

  // Stage 1: accepted beat waiting for its memory read.
  logic          s1_v_r;
  logic [1:0]    s1_kind_r;
  logic [AW-1:0] s1_conn_r;
  logic [3:0]    s1_conn4_r;
  logic [7:0]    s1_byte_r;
  logic          s1_ok_r;

  logic          in_fire;
  logic          conn_ok;
  logic          s1_adv;
  logic [AW-1:0] in_idx;

  // Stage 1 advances when it is empty or the job register will be free.
  assign s1_adv = !s1_v_r || job_free;
  assign conn_ok = 32'(in_ch.conn) < CONNECTIONS;
  assign in_idx = AW'(in_ch.conn);
  assign in_ch.ready = !clr_busy_r && s1_adv;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_fire && conn_ok && in_ch.kind != shp_pkg::IK_RESERVED;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_kind_r  <= in_ch.kind;
      s1_conn_r  <= in_idx;
      s1_conn4_r <= in_ch.conn;
      s1_byte_r  <= in_ch.data_byte;
      s1_ok_r    <= in_ch.connect_ok;
    end
  end

  // Slot memory with registered read and forwarding of the previous write.
  shp_pkg::slot_t mem [CONNECTIONS];
  shp_pkg::slot_t rd_r;
  shp_pkg::slot_t wr_data;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic           fwd_r;
  shp_pkg::slot_t fwd_data_r;
  shp_pkg::slot_t cur;
  logic           s1_fire;

  assign s1_fire = s1_v_r && s1_adv;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (s1_adv) rd_r <= mem[in_idx];
  end

  // Forward when the slot now being read was written this cycle; hold the choice while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (s1_adv) begin
      fwd_r <= s1_fire && (s1_conn_r == in_idx);
    end
  end
  always_ff @(posedge clk) begin
    if (s1_adv) fwd_data_r <= wr_data;
  end
  assign cur = fwd_r ? fwd_data_r : rd_r;

  // Parse one beat against its slot state.
  shp_pkg::slot_t nx;
  shp_pkg::job_t  jb;
  logic [15:0]    pt;
  always_comb begin
    nx = cur;
    jb = '0;
    jb.seq = shp_pkg::RS_NONE;
    jb.conn = s1_conn4_r;
    jb.kind = shp_pkg::OK_REPLY;
    pt = '0;
    priority if (s1_kind_r == shp_pkg::IK_OPEN) begin
      nx = '0;
      nx.phase = shp_pkg::PH_VERSION;
    end else if (s1_kind_r == shp_pkg::IK_OUTCOME) begin
      if (cur.phase == shp_pkg::PH_WAIT_V4) begin
        jb.seq = s1_ok_r ? shp_pkg::RS_V4_GRANT : shp_pkg::RS_V4_REJECT;
        nx.phase = s1_ok_r ? shp_pkg::PH_RELAY : shp_pkg::PH_FREE;
      end else if (cur.phase == shp_pkg::PH_WAIT_V5) begin
        jb.seq = s1_ok_r ? shp_pkg::RS_V5_OK : shp_pkg::RS_V5_UNREACH;
        nx.phase = s1_ok_r ? shp_pkg::PH_RELAY : shp_pkg::PH_FREE;
      end
    end else begin
      unique case (cur.phase)
        shp_pkg::PH_VERSION: begin
          if (s1_byte_r == 8'd4) nx.phase = shp_pkg::PH_V4_CMD;
          else if (s1_byte_r == 8'd5) nx.phase = shp_pkg::PH_V5_NMETH;
          else begin
            jb.seq = shp_pkg::RS_GENERAL;
            nx.phase = shp_pkg::PH_FREE;
          end
        end
        shp_pkg::PH_V4_CMD: begin
          if (s1_byte_r != 8'd1) begin
            jb.seq = shp_pkg::RS_V4_REJECT;
            nx.phase = shp_pkg::PH_FREE;
          end else begin
            nx.phase = shp_pkg::PH_V4_DEST;
            nx.byte_count = '0;
          end
        end
        shp_pkg::PH_V4_DEST: begin
          if (cur.byte_count == 8'd0) nx.port_high = s1_byte_r;
          else if (cur.byte_count == 8'd1) nx.port_low = s1_byte_r;
          else begin
            jb.seq = shp_pkg::RS_SINGLE;
            jb.kind = shp_pkg::OK_DEST;
            jb.data = s1_byte_r;
          end
          nx.byte_count = cur.byte_count + 8'd1;
          if (nx.byte_count >= 8'd6) begin
            nx.phase = shp_pkg::PH_V4_USER;
            nx.byte_count = '0;
          end
        end
        shp_pkg::PH_V4_USER: begin
          if (s1_byte_r == 8'd0) begin
            nx.dest_type = shp_pkg::AT_IPV4;
            jb.seq = shp_pkg::RS_SINGLE;
            jb.kind = shp_pkg::OK_CONNECT;
            jb.port = {cur.port_high, cur.port_low};
            nx.phase = shp_pkg::PH_WAIT_V4;
          end
        end
        shp_pkg::PH_V5_NMETH: begin
          nx.noauth_seen = 1'b0;
          if (s1_byte_r == 8'd0) begin
            jb.seq = shp_pkg::RS_V5_NOMETHOD;
            nx.phase = shp_pkg::PH_FREE;
          end else begin
            nx.byte_count = s1_byte_r;
            nx.phase = shp_pkg::PH_V5_METHODS;
          end
        end
        shp_pkg::PH_V5_METHODS: begin
          if (s1_byte_r == 8'd0) nx.noauth_seen = 1'b1;
          nx.byte_count = cur.byte_count - 8'd1;
          if (nx.byte_count == 8'd0) begin
            if (nx.noauth_seen) begin
              jb.seq = shp_pkg::RS_V5_NOAUTH;
              nx.phase = shp_pkg::PH_V5_HDR;
            end else begin
              jb.seq = shp_pkg::RS_V5_NOMETHOD;
              nx.phase = shp_pkg::PH_FREE;
            end
          end
        end
        shp_pkg::PH_V5_HDR: begin
          if (cur.byte_count == 8'd1) nx.port_high = s1_byte_r;
          if (cur.byte_count < 8'd3) begin
            nx.byte_count = cur.byte_count + 8'd1;
          end else begin
            nx.byte_count = '0;
            if (cur.port_high != 8'd1) begin
              jb.seq = shp_pkg::RS_V5_BADCMD;
              nx.phase = shp_pkg::PH_FREE;
            end else if (s1_byte_r == 8'd1) begin
              nx.dest_type = shp_pkg::AT_IPV4;
              nx.phase = shp_pkg::PH_V5_IPV4;
            end else if (s1_byte_r == 8'd3) begin
              nx.dest_type = shp_pkg::AT_DOMAIN;
              nx.phase = shp_pkg::PH_V5_DOMLEN;
            end else begin
              nx.dest_type = shp_pkg::AT_OTHER;
              jb.seq = shp_pkg::RS_SINGLE;
              jb.kind = shp_pkg::OK_CONNECT;
              jb.atype = shp_pkg::AT_OTHER;
              nx.phase = shp_pkg::PH_WAIT_V5;
            end
          end
        end
        shp_pkg::PH_V5_IPV4: begin
          if (cur.byte_count < 8'd4) begin
            jb.seq = shp_pkg::RS_SINGLE;
            jb.kind = shp_pkg::OK_DEST;
            jb.data = s1_byte_r;
            nx.byte_count = cur.byte_count + 8'd1;
          end else if (cur.byte_count == 8'd4) begin
            nx.port_high = s1_byte_r;
            nx.byte_count = 8'd5;
          end else begin
            jb.seq = shp_pkg::RS_SINGLE;
            jb.kind = shp_pkg::OK_CONNECT;
            jb.port = {cur.port_high, s1_byte_r};
            nx.byte_count = '0;
            nx.phase = shp_pkg::PH_WAIT_V5;
          end
        end
        shp_pkg::PH_V5_DOMLEN: begin
          nx.byte_count = s1_byte_r;
          nx.phase = (s1_byte_r == 8'd0) ? shp_pkg::PH_V5_PORT : shp_pkg::PH_V5_DOMAIN;
        end
        shp_pkg::PH_V5_DOMAIN: begin
          jb.seq = shp_pkg::RS_SINGLE;
          jb.kind = shp_pkg::OK_DEST;
          jb.data = s1_byte_r;
          nx.byte_count = cur.byte_count - 8'd1;
          if (nx.byte_count == 8'd0) nx.phase = shp_pkg::PH_V5_PORT;
        end
        shp_pkg::PH_V5_PORT: begin
          if (cur.byte_count == 8'd0) begin
            nx.port_high = s1_byte_r;
            nx.byte_count = 8'd1;
          end else begin
            jb.seq = shp_pkg::RS_SINGLE;
            jb.kind = shp_pkg::OK_CONNECT;
            jb.port = {cur.port_high, s1_byte_r};
            jb.atype = shp_pkg::AT_DOMAIN;
            nx.byte_count = '0;
            nx.phase = shp_pkg::PH_WAIT_V5;
          end
        end
        shp_pkg::PH_RELAY: begin
          jb.seq = shp_pkg::RS_SINGLE;
          jb.kind = shp_pkg::OK_RELAY;
          jb.data = s1_byte_r;
        end
        default: begin
        end
      endcase
    end
    pt = jb.port;
    jb.port = pt;
  end

  // Memory write: clearing pass, else the parsed beat.
  always_comb begin
    wr_en = clr_busy_r || s1_fire;
    wr_addr = clr_busy_r ? clr_idx_r : s1_conn_r;
    wr_data = clr_busy_r ? shp_pkg::slot_t'('0) : nx;
  end

  // Result emitter: walks the reply sequence, one result per beat.
  logic [3:0] len;
  logic       out_fire;
  assign len = shp_pkg::seq_len(job_r.seq);
  assign out_fire = out_ch.valid && out_ch.ready;
  assign job_done = out_fire && (job_idx_r == len - 4'd1);
  assign job_free = !job_v_r || job_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r   <= 1'b0;
      job_idx_r <= '0;
    end else if (job_free) begin
      job_v_r   <= s1_fire && jb.seq != shp_pkg::RS_NONE;
      job_idx_r <= '0;
    end else if (out_fire) begin
      job_idx_r <= job_idx_r + 4'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (job_free) job_r <= jb;
  end

  // Byte and kind of the current result in a reply sequence.
  logic [7:0]        rb;
  shp_pkg::out_kind_t rk;
  logic [7:0]        bound_b;
  always_comb begin
    unique case (job_idx_r)
      4'd4:    bound_b = server_port_r[15:8];
      4'd5:    bound_b = server_port_r[7:0];
      4'd6:    bound_b = server_addr_r[31:24];
      4'd7:    bound_b = server_addr_r[23:16];
      4'd8:    bound_b = server_addr_r[15:8];
      default: bound_b = server_addr_r[7:0];
    endcase
    rb = 8'd0;
    rk = shp_pkg::OK_REPLY;
    unique case (job_r.seq)
      shp_pkg::RS_GENERAL: begin
        if (job_idx_r == 4'd0) rb = 8'h05;
        else if (job_idx_r == 4'd1) rb = 8'h01;
        else if (job_idx_r == 4'd4) rk = shp_pkg::OK_CLOSE;
      end
      shp_pkg::RS_V4_REJECT, shp_pkg::RS_V4_GRANT: begin
        if (job_idx_r == 4'd1) rb = (job_r.seq == shp_pkg::RS_V4_GRANT) ? 8'h5A : 8'h5B;
        else if (job_idx_r == 4'd8) begin
          rk = (job_r.seq == shp_pkg::RS_V4_GRANT) ? shp_pkg::OK_NOWRELAY : shp_pkg::OK_CLOSE;
        end
      end
      shp_pkg::RS_V5_BADCMD, shp_pkg::RS_V5_OK, shp_pkg::RS_V5_UNREACH: begin
        if (job_idx_r == 4'd0) rb = 8'h05;
        else if (job_idx_r == 4'd1) begin
          rb = (job_r.seq == shp_pkg::RS_V5_BADCMD) ? 8'h07 :
               (job_r.seq == shp_pkg::RS_V5_UNREACH) ? 8'h04 : 8'h00;
        end else if (job_idx_r == 4'd3) rb = 8'h01;
        else if (job_idx_r == 4'd4 && job_r.seq == shp_pkg::RS_V5_UNREACH) begin
          rk = shp_pkg::OK_CLOSE;
        end else if (job_idx_r == 4'd10) begin
          rk = (job_r.seq == shp_pkg::RS_V5_OK) ? shp_pkg::OK_NOWRELAY : shp_pkg::OK_CLOSE;
        end else if (job_idx_r >= 4'd4) rb = bound_b;
      end
      shp_pkg::RS_V5_NOMETHOD: begin
        if (job_idx_r == 4'd0) rb = 8'h05;
        else if (job_idx_r == 4'd1) rb = 8'hFF;
        else rk = shp_pkg::OK_CLOSE;
      end
      shp_pkg::RS_V5_NOAUTH: begin
        if (job_idx_r == 4'd0) rb = 8'h05;
      end
      shp_pkg::RS_SINGLE: begin
        rb = job_r.data;
        rk = job_r.kind;
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid     = job_v_r;
  assign out_ch.out_conn  = job_r.conn;
  assign out_ch.out_kind  = rk;
  assign out_ch.out_byte  = rb;
  assign out_ch.dest_port = (job_r.seq == shp_pkg::RS_SINGLE) ? job_r.port : 16'd0;
  assign out_ch.addr_type = (job_r.seq == shp_pkg::RS_SINGLE) ? job_r.atype : 2'd0;
  assign out_ch.last      = job_idx_r == len - 4'd1;

endmodule

// ----- sv/shp_checker.sv -----
// Port-level checker for the SOCKS handshake parser, bound to the top level.
// Depends on shp_pkg and the assertion macro header.
`include "socks_handshake_parser_assert.svh"
module shp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_byte,
  input logic [15:0] dest_port,
  input logic [1:0]  addr_type,
  input logic        last
);

  // A close or now-relaying mark always ends the results of its beat.
  `SHP_ASSERT_IMPL(a_mark_last, clk, rst_n,
    out_valid && (out_kind == 3'(shp_pkg::OK_CLOSE) || out_kind == 3'(shp_pkg::OK_NOWRELAY)),
    last, "close or relay mark not last")
  // Port and address type appear only with a connect request.
  `SHP_ASSERT_IMPL(a_port_zero, clk, rst_n,
    out_valid && out_kind != 3'(shp_pkg::OK_CONNECT),
    dest_port == 16'd0 && addr_type == 2'd0, "port outside connect request")
  // A connect request carries no byte and is the only result of its beat.
  `SHP_ASSERT_IMPL(a_conn_req, clk, rst_n,
    out_valid && out_kind == 3'(shp_pkg::OK_CONNECT),
    out_byte == 8'd0 && last, "malformed connect request")
  // A stalled result holds its kind.
  `SHP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_kind), "stalled result changed")
  // A reply that is not finished goes on with its next result.
  `SHP_ASSERT_NEXT(a_more, clk, rst_n, out_valid && out_ready && !last,
    out_valid, "reply cut short")

endmodule

bind socks_handshake_parser shp_checker u_shp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.out_kind),
  .out_byte  (out_ch.out_byte),
  .dest_port (out_ch.dest_port),
  .addr_type (out_ch.addr_type),
  .last      (out_ch.last)
);
